@@ sv/pnq_pkg.sv @@
// ----------------------------------------------------------------------------
// pnq_pkg
// Shared types, widths and the fixed colour palette of the nearest palette
// colour quantizer.
// ----------------------------------------------------------------------------
`default_nettype none

package pnq_pkg;

    // Widths of the pixel channels on the port and inside the datapath.
    localparam int CHAN_IN_W  = 8;
    localparam int CHAN_W     = 6;
    localparam int IDX_W      = 4;
    localparam int DIST_W     = 14;   // 3 * 63 * 63 = 11907 fits in 14 bits

    // Palette size and how much of it is searched.
    localparam int TABLE_SIZE = 16;
    localparam int NUM_COLORS = 16;
    localparam int NUM_SEARCH = (NUM_COLORS < TABLE_SIZE) ? NUM_COLORS : TABLE_SIZE;

    // The search is split into groups of four in the first compare stage.
    localparam int GROUP_SIZE = 4;
    localparam int NUM_GROUPS = (NUM_SEARCH + GROUP_SIZE - 1) / GROUP_SIZE;

    // Number of register stages from input to output.
    localparam int PIPE_DEPTH = 4;

    typedef logic [CHAN_IN_W-1:0] chan_in_t;
    typedef logic [CHAN_W-1:0]    chan_t;
    typedef logic [IDX_W-1:0]     idx_t;
    typedef logic [DIST_W-1:0]    dist_t;

    typedef struct packed {
        chan_t r;
        chan_t g;
        chan_t b;
    } color_t;

    // Fixed palette, 6 bits per channel.
    localparam color_t PALETTE [TABLE_SIZE] = '{
        '{6'd7,  6'd7,  6'd11}, '{6'd34, 6'd45, 6'd62},
        '{6'd41, 6'd56, 6'd40}, '{6'd29, 6'd49, 6'd59},
        '{6'd60, 6'd34, 6'd42}, '{6'd50, 6'd41, 6'd61},
        '{6'd62, 6'd44, 6'd33}, '{6'd12, 6'd12, 6'd17},
        '{6'd6,  6'd6,  6'd9},  '{6'd45, 6'd47, 6'd63},
        '{6'd37, 6'd56, 6'd53}, '{6'd34, 6'd55, 6'd58},
        '{6'd58, 6'd40, 6'd43}, '{6'd61, 6'd48, 6'd57},
        '{6'd62, 6'd56, 6'd43}, '{6'd51, 6'd53, 6'd61}
    };

endpackage

`default_nettype wire

@@ sv/pnq_pixel_if.sv @@
// ----------------------------------------------------------------------------
// pnq_pixel_if
// Pixel channel: one 24-bit RGB pixel per word, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface pnq_pixel_if
    import pnq_pkg::*;
    ;

    logic     valid;
    logic     ready;
    chan_in_t red;
    chan_in_t green;
    chan_in_t blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);

endinterface

`default_nettype wire

@@ sv/pnq_index_if.sv @@
// ----------------------------------------------------------------------------
// pnq_index_if
// Result channel: one palette index per word, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface pnq_index_if
    import pnq_pkg::*;
    ;

    logic valid;
    logic ready;
    idx_t color_index;

    modport source (output valid, output color_index, input ready);
    modport sink   (input valid, input color_index, output ready);

endinterface

`default_nettype wire

@@ sv/palette_nearest_color_quantizer.sv @@
// ----------------------------------------------------------------------------
// palette_nearest_color_quantizer
// Maps each RGB pixel to the index of the nearest entry of a fixed palette.
// ----------------------------------------------------------------------------
// Each pixel word is cut to 6 bits per channel and compared with the fixed
// 16-entry palette by squared distance; the result word carries the index of
// the nearest entry, the lowest index winning on a tie. The block takes one
// pixel per clock unless the result channel stalls, and gives one result per
// pixel, in order. It has four register stages: input capture, per-entry
// distances, compare within groups of four, and the final compare into the
// output register. The edge that accepts a pixel loads the first stage, and
// the result moves on through the later stages. Backpressure on the result
// channel stalls the pipeline stage by stage, so empty stages still fill
// while the output waits. Nothing is kept between pixels.
`default_nettype none

module palette_nearest_color_quantizer
    import pnq_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    pnq_pixel_if.sink   pixel,
    pnq_index_if.source result
);

    // Stage valid bits and advance enables.
    logic s1_valid_reg, s1_valid_next;
    logic s2_valid_reg, s2_valid_next;
    logic s3_valid_reg, s3_valid_next;
    logic s4_valid_reg, s4_valid_next;
    logic adv1, adv2, adv3, adv4;

    // Stage payloads.
    color_t s1_color_reg;
    dist_t  s2_dist_next [NUM_SEARCH];
    dist_t  s2_dist_reg  [NUM_SEARCH];
    dist_t  s3_dist_next [NUM_GROUPS];
    idx_t   s3_idx_next  [NUM_GROUPS];
    dist_t  s3_dist_reg  [NUM_GROUPS];
    idx_t   s3_idx_reg   [NUM_GROUPS];
    idx_t   s4_idx_next;
    idx_t   s4_idx_reg;

    // A stage moves on when it is empty or the stage after it moves on.
    assign adv4 = !s4_valid_reg || result.ready;
    assign adv3 = !s3_valid_reg || adv4;
    assign adv2 = !s2_valid_reg || adv3;
    assign adv1 = !s1_valid_reg || adv2;

    assign pixel.ready = adv1;

    assign s1_valid_next = adv1 ? pixel.valid  : s1_valid_reg;
    assign s2_valid_next = adv2 ? s1_valid_reg : s2_valid_reg;
    assign s3_valid_next = adv3 ? s2_valid_reg : s3_valid_reg;
    assign s4_valid_next = adv4 ? s3_valid_reg : s4_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
            s3_valid_reg <= s3_valid_next;
            s4_valid_reg <= s4_valid_next;
        end
    end

    // Distance to every palette entry, one unit per entry.
    for (genvar k = 0; k < NUM_SEARCH; k++)
    begin : g_entry
        pnq_sq_dist u_sq_dist (
            .pixel  (s1_color_reg),
            .entry  (PALETTE[k]),
            .sq_sum (s2_dist_next[k])
        );
    end

    // Nearest entry within each group of four; strict compare keeps the
    // lower index on a tie.
    always_comb
    begin
        int k;
        for (int g = 0; g < NUM_GROUPS; g++)
        begin
            s3_dist_next[g] = s2_dist_reg[g * GROUP_SIZE];
            s3_idx_next[g]  = IDX_W'(g * GROUP_SIZE);
            for (int j = 1; j < GROUP_SIZE; j++)
            begin
                k = g * GROUP_SIZE + j;
                if (k < NUM_SEARCH)
                begin
                    if (s2_dist_reg[k] < s3_dist_next[g])
                    begin
                        s3_dist_next[g] = s2_dist_reg[k];
                        s3_idx_next[g]  = IDX_W'(k);
                    end
                end
            end
        end
    end

    // Nearest over the group winners, groups taken in ascending order.
    always_comb
    begin
        dist_t best_dist;
        best_dist   = s3_dist_reg[0];
        s4_idx_next = s3_idx_reg[0];
        for (int g = 1; g < NUM_GROUPS; g++)
        begin
            if (s3_dist_reg[g] < best_dist)
            begin
                best_dist   = s3_dist_reg[g];
                s4_idx_next = s3_idx_reg[g];
            end
        end
    end

    // Payload registers, loaded when their stage advances.
    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            s1_color_reg.r <= pixel.red[CHAN_IN_W-1 -: CHAN_W];
            s1_color_reg.g <= pixel.green[CHAN_IN_W-1 -: CHAN_W];
            s1_color_reg.b <= pixel.blue[CHAN_IN_W-1 -: CHAN_W];
        end
        if (adv2)
        begin
            s2_dist_reg <= s2_dist_next;
        end
        if (adv3)
        begin
            s3_dist_reg <= s3_dist_next;
            s3_idx_reg  <= s3_idx_next;
        end
        if (adv4)
        begin
            s4_idx_reg <= s4_idx_next;
        end
    end

    assign result.valid       = s4_valid_reg;
    assign result.color_index = s4_idx_reg;

endmodule

`default_nettype wire

@@ sv/pnq_sq_dist.sv @@
// ----------------------------------------------------------------------------
// pnq_sq_dist
// Squared Euclidean distance between a 6-bit-per-channel pixel and one
// palette entry.
// ----------------------------------------------------------------------------
`default_nettype none

module pnq_sq_dist
    import pnq_pkg::*;
(
    input  color_t pixel,
    input  color_t entry,
    output dist_t  sq_sum
);

    chan_t              diff_r;
    chan_t              diff_g;
    chan_t              diff_b;
    logic [2*CHAN_W-1:0] sq_r;
    logic [2*CHAN_W-1:0] sq_g;
    logic [2*CHAN_W-1:0] sq_b;

    // Absolute difference per channel.
    assign diff_r = (pixel.r >= entry.r) ? (pixel.r - entry.r) : (entry.r - pixel.r);
    assign diff_g = (pixel.g >= entry.g) ? (pixel.g - entry.g) : (entry.g - pixel.g);
    assign diff_b = (pixel.b >= entry.b) ? (pixel.b - entry.b) : (entry.b - pixel.b);

    // Small 6 x 6 squares, then the sum of the three.
    assign sq_r = {{CHAN_W{1'b0}}, diff_r} * {{CHAN_W{1'b0}}, diff_r};
    assign sq_g = {{CHAN_W{1'b0}}, diff_g} * {{CHAN_W{1'b0}}, diff_g};
    assign sq_b = {{CHAN_W{1'b0}}, diff_b} * {{CHAN_W{1'b0}}, diff_b};

    assign sq_sum = DIST_W'(sq_r) + DIST_W'(sq_g) + DIST_W'(sq_b);

endmodule

`default_nettype wire

@@ sv/pnq_checker.sv @@
// ----------------------------------------------------------------------------
// pnq_checker
// Port-level checks of the nearest palette colour quantizer, bound to the
// top level.
// ----------------------------------------------------------------------------
`default_nettype none

module pnq_checker
    import pnq_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic pixel_valid,
    input wire logic pixel_ready,
    input wire logic result_valid,
    input wire logic result_ready,
    input wire idx_t color_index
);

    localparam int CNT_W = $clog2(PIPE_DEPTH + 1);

    logic             in_word;
    logic             out_word;
    logic [CNT_W-1:0] pending_reg;
    logic [CNT_W-1:0] pending_next;

    assign in_word  = pixel_valid && pixel_ready;
    assign out_word = result_valid && result_ready;

    // Words accepted but not yet delivered.
    always_comb
    begin
        pending_next = pending_reg;
        if (in_word && !out_word)
        begin
            pending_next = pending_reg + CNT_W'(1);
        end
        else if (!in_word && out_word)
        begin
            pending_next = pending_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    // A stalled result word holds still.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(color_index))
        else $error("result word changed while stalled");

    // No result word without a pixel word behind it.
    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> pending_reg != '0)
        else $error("result word shown with no pixel outstanding");

    // The pipeline never holds more words than it has stages.
    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= CNT_W'(PIPE_DEPTH))
        else $error("more words outstanding than pipeline stages");

    // An empty pipeline always takes a pixel.
    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg == '0 |-> pixel_ready)
        else $error("empty pipeline refused a pixel word");

    // Only searched palette entries are ever reported.
    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> 32'(color_index) < NUM_SEARCH)
        else $error("index outside the searched palette");

endmodule

bind palette_nearest_color_quantizer pnq_checker u_pnq_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .pixel_valid  (pixel.valid),
    .pixel_ready  (pixel.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .color_index  (result.color_index)
);

`default_nettype wire
